@@ rtl/jhd_pkg.sv @@
// jhd_pkg: shared types and constants for the huffman block decoder
// no dependencies; imported by the request channel interface, the core and the bench

package jhd_pkg;

    localparam int TREE_NODES  = 512;
    localparam int NODE_W      = 9;
    localparam int TAB_AW      = NODE_W + 1;
    localparam int NODE_BITS   = 27;
    localparam int BLOCK_COEFS = 64;

    typedef logic [1:0]  cmd_t;
    typedef logic [1:0]  phase_t;
    typedef logic [NODE_W-1:0] node_t;

    localparam cmd_t CMD_BYTE    = 2'd0;
    localparam cmd_t CMD_LOAD    = 2'd1;
    localparam cmd_t CMD_RESTART = 2'd2;
    localparam cmd_t CMD_UNUSED  = 2'd3;

    localparam phase_t PH_DC_SYM   = 2'd0;
    localparam phase_t PH_DC_EXTRA = 2'd1;
    localparam phase_t PH_AC_SYM   = 2'd2;
    localparam phase_t PH_AC_EXTRA = 2'd3;

    localparam logic [7:0] MARKER_BYTE = 8'hFF;

endpackage

@@ rtl/jhd_channels.sv @@
// jhd_channels: valid/ready channel interfaces for request and result words
// depends on jhd_pkg

interface jhd_req_if
    import jhd_pkg::*;
();
    logic       valid;
    logic       ready;
    cmd_t       cmd;
    logic [7:0] data_byte;
    logic       stream_end;
    logic       table_select;
    node_t      node_index;
    logic       node_is_leaf;
    node_t      child_zero;
    node_t      child_one;
    logic [7:0] leaf_symbol;

    modport source (output valid, cmd, data_byte, stream_end, table_select, node_index,
                    node_is_leaf, child_zero, child_one, leaf_symbol, input ready);
    modport sink (input valid, cmd, data_byte, stream_end, table_select, node_index,
                  node_is_leaf, child_zero, child_one, leaf_symbol, output ready);
endinterface

interface jhd_rsp_if;
    logic               valid;
    logic               ready;
    logic [5:0]         coef_index;
    logic signed [15:0] coef_value;
    logic [5:0]         zeros_before;
    logic               block_done;
    logic               error;

    modport source (output valid, coef_index, coef_value, zeros_before, block_done, error,
                    input ready);
    modport sink (input valid, coef_index, coef_value, zeros_before, block_done, error,
                  output ready);
endinterface

@@ rtl/jpeg_huffman_block_decoder_core.sv @@
// jpeg_huffman_block_decoder_core: bit-serial huffman decoder for one component
// depends on jhd_pkg and the channel interfaces in jhd_channels.sv
//
//  channel | dir | word                                   | handshake
//  req     | in  | stream byte, tree node load or restart  | valid/ready
//  rsp     | out | coefficient, block end or error         | valid/ready
//
// a stream byte is accepted in ST_IDLE; each bit then either walks the code tree
// through ST_BIT, ST_RD1 and ST_RD2 (two dependent reads of the node table's single
// read port) or shifts one magnitude bit in ST_BIT, and ST_END closes the byte
// loads and restarts are taken in ST_IDLE; reset leaves the node table unwritten
// a full result register with rsp.ready low holds the walk at a leaf or a magnitude bit

module jpeg_huffman_block_decoder_core
    import jhd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    jhd_req_if.sink   req,
    jhd_rsp_if.source rsp
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_BIT  = 3'd1;
    localparam logic [2:0] ST_RD1  = 3'd2;
    localparam logic [2:0] ST_RD2  = 3'd3;
    localparam logic [2:0] ST_END  = 3'd4;

    logic [NODE_BITS-1:0] node_mem [0:2*TREE_NODES-1];
    logic [NODE_BITS-1:0] mem_q;
    logic                 mem_re, mem_we;
    logic [TAB_AW-1:0]    mem_ra, mem_wa;
    logic [NODE_BITS-1:0] mem_wd;

    logic [2:0]  state_reg, state_next;
    logic [7:0]  sh_reg, sh_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        ff_reg, ff_next;
    logic        end_reg, end_next;
    phase_t      phase_reg, phase_next;
    node_t       cur_reg, cur_next;
    node_t       nxt_reg, nxt_next;
    logic [3:0]  left_reg, left_next;
    logic [3:0]  size_reg, size_next;
    logic [15:0] ev_reg, ev_next;
    logic [6:0]  pos_reg, pos_next;
    logic [5:0]  zr_reg, zr_next;
    logic [15:0] pred_reg, pred_next;
    logic        skip_reg, skip_next;

    logic        ov_reg, ov_next;
    logic [5:0]  oidx_reg, oidx_next;
    logic [15:0] oval_reg, oval_next;
    logic [5:0]  ozb_reg, ozb_next;
    logic        odone_reg, odone_next;
    logic        oerr_reg, oerr_next;

    logic        can_emit, adv, cur_bit;
    logic [15:0] ev_shift, mag_val, pred_sum;
    logic [3:0]  left_dec, msize;
    node_t       child;
    logic [3:0]  run, sym_size;
    logic [6:0]  pos_run, pos_zrl;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            node_mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            mem_q <= node_mem[mem_ra];
        end
    end

    assign req.ready        = (state_reg == ST_IDLE);
    assign rsp.valid        = ov_reg;
    assign rsp.coef_index   = oidx_reg;
    assign rsp.coef_value   = oval_reg;
    assign rsp.zeros_before = ozb_reg;
    assign rsp.block_done   = odone_reg;
    assign rsp.error        = oerr_reg;

    assign can_emit = !ov_reg || rsp.ready;
    assign cur_bit  = sh_reg[7];
    assign ev_shift = {ev_reg[14:0], cur_bit};
    assign left_dec = (left_reg != 4'd0) ? left_reg - 4'd1 : 4'd0;
    assign msize    = (size_reg == 4'd0) ? 4'd1 : size_reg;
    // sign from the top extra bit; a clear top bit means a negative value
    assign mag_val  = ev_shift[msize - 4'd1] ? ev_shift
                    : ev_shift - (16'd1 << msize) + 16'd1;
    assign pred_sum = pred_reg + mag_val;
    assign child    = cur_bit ? mem_q[16:8] : mem_q[25:17];
    assign run      = mem_q[7:4];
    assign sym_size = mem_q[3:0];
    assign pos_run  = pos_reg + {3'd0, run};
    assign pos_zrl  = pos_reg + 7'd16;

    always_comb
    begin
        state_next = state_reg;
        sh_next    = sh_reg;
        cnt_next   = cnt_reg;
        ff_next    = ff_reg;
        end_next   = end_reg;
        phase_next = phase_reg;
        cur_next   = cur_reg;
        nxt_next   = nxt_reg;
        left_next  = left_reg;
        size_next  = size_reg;
        ev_next    = ev_reg;
        pos_next   = pos_reg;
        zr_next    = zr_reg;
        pred_next  = pred_reg;
        skip_next  = skip_reg;
        ov_next    = ov_reg && !rsp.ready;
        oidx_next  = oidx_reg;
        oval_next  = oval_reg;
        ozb_next   = ozb_reg;
        odone_next = odone_reg;
        oerr_next  = oerr_reg;
        mem_re     = 1'b0;
        mem_ra     = {phase_reg[1], cur_reg};
        mem_we     = 1'b0;
        mem_wa     = {req.table_select, req.node_index};
        mem_wd     = {req.node_is_leaf, req.child_zero, req.child_one, req.leaf_symbol};
        adv        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    unique case (req.cmd)
                        CMD_BYTE:
                        begin
                            sh_next   = req.data_byte;
                            cnt_next  = 4'd8;
                            end_next  = req.stream_end;
                            ff_next   = (req.data_byte == MARKER_BYTE) && !skip_reg;
                            skip_next = 1'b0;
                            state_next = skip_reg ? ST_END : ST_BIT;
                        end
                        CMD_LOAD:
                        begin
                            mem_we = ({1'b0, req.node_index} < TAB_AW'(TREE_NODES));
                        end
                        CMD_RESTART:
                        begin
                            phase_next = PH_DC_SYM;
                            cur_next   = '0;
                            pos_next   = '0;
                            zr_next    = '0;
                            left_next  = '0;
                            size_next  = '0;
                            ev_next    = '0;
                            pred_next  = '0;
                            skip_next  = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_BIT:
            begin
                if (!phase_reg[0])
                begin
                    mem_re     = 1'b1;
                    state_next = ST_RD1;
                end
                else if (can_emit)
                begin
                    adv       = 1'b1;
                    ev_next   = ev_shift;
                    left_next = left_dec;
                    if (left_dec == 4'd0)
                    begin
                        ov_next  = 1'b1;
                        oval_next = (phase_reg == PH_DC_EXTRA) ? pred_sum : mag_val;
                        ozb_next = '0;
                        oerr_next = 1'b0;
                        if (phase_reg == PH_DC_EXTRA)
                        begin
                            oidx_next  = '0;
                            odone_next = 1'b0;
                            pred_next  = pred_sum;
                            phase_next = PH_AC_SYM;
                            cur_next   = '0;
                            pos_next   = 7'd1;
                            zr_next    = '0;
                        end
                        else
                        begin
                            oidx_next  = pos_reg[5:0];
                            ozb_next   = zr_reg;
                            odone_next = (pos_reg >= 7'(BLOCK_COEFS - 1));
                            if (pos_reg >= 7'(BLOCK_COEFS - 1))
                            begin
                                phase_next = PH_DC_SYM;
                                cur_next   = '0;
                                pos_next   = '0;
                                zr_next    = '0;
                                left_next  = '0;
                                size_next  = '0;
                                ev_next    = '0;
                            end
                            else
                            begin
                                pos_next   = pos_reg + 7'd1;
                                zr_next    = '0;
                                phase_next = PH_AC_SYM;
                            end
                        end
                    end
                end
            end
            ST_RD1:
            begin
                // a child beyond the table falls back to the root
                nxt_next   = ({1'b0, child} >= TAB_AW'(TREE_NODES)) ? '0 : child;
                mem_re     = 1'b1;
                mem_ra     = {phase_reg[1],
                              ({1'b0, child} >= TAB_AW'(TREE_NODES)) ? node_t'(0) : child};
                state_next = ST_RD2;
            end
            ST_RD2:
            begin
                if (!mem_q[NODE_BITS-1])
                begin
                    cur_next = nxt_reg;
                    adv      = 1'b1;
                end
                else if (can_emit)
                begin
                    cur_next = '0;
                    adv      = 1'b1;
                    if (phase_reg == PH_DC_SYM)
                    begin
                        if (sym_size == 4'd0)
                        begin
                            ov_next    = 1'b1;
                            oidx_next  = '0;
                            oval_next  = pred_reg;
                            ozb_next   = '0;
                            odone_next = 1'b0;
                            oerr_next  = 1'b0;
                            phase_next = PH_AC_SYM;
                            pos_next   = 7'd1;
                            zr_next    = '0;
                        end
                        else
                        begin
                            size_next  = sym_size;
                            left_next  = sym_size;
                            ev_next    = '0;
                            phase_next = PH_DC_EXTRA;
                        end
                    end
                    else if (sym_size == 4'd0)
                    begin
                        if (run == 4'd0)
                        begin
                            // end of block: trailing zeros run out to the last index
                            ov_next    = 1'b1;
                            oidx_next  = 6'(BLOCK_COEFS - 1);
                            oval_next  = '0;
                            ozb_next   = zr_reg + 6'(7'(BLOCK_COEFS) - pos_reg);
                            odone_next = 1'b1;
                            oerr_next  = 1'b0;
                            phase_next = PH_DC_SYM;
                            pos_next   = '0;
                            zr_next    = '0;
                            left_next  = '0;
                            size_next  = '0;
                            ev_next    = '0;
                        end
                        else if (run == 4'd15)
                        begin
                            if (pos_zrl > 7'(BLOCK_COEFS) || pos_zrl == 7'(BLOCK_COEFS))
                            begin
                                ov_next    = 1'b1;
                                oidx_next  = (pos_zrl == 7'(BLOCK_COEFS))
                                           ? 6'(BLOCK_COEFS - 1) : 6'd0;
                                oval_next  = '0;
                                ozb_next   = (pos_zrl == 7'(BLOCK_COEFS))
                                           ? zr_reg + 6'd16 : 6'd0;
                                odone_next = 1'b1;
                                oerr_next  = (pos_zrl != 7'(BLOCK_COEFS));
                                phase_next = PH_DC_SYM;
                                pos_next   = '0;
                                zr_next    = '0;
                                left_next  = '0;
                                size_next  = '0;
                                ev_next    = '0;
                            end
                            else
                            begin
                                pos_next = pos_zrl;
                                zr_next  = zr_reg + 6'd16;
                            end
                        end
                    end
                    else if (pos_run > 7'(BLOCK_COEFS - 1))
                    begin
                        ov_next    = 1'b1;
                        oidx_next  = '0;
                        oval_next  = '0;
                        ozb_next   = '0;
                        odone_next = 1'b1;
                        oerr_next  = 1'b1;
                        phase_next = PH_DC_SYM;
                        pos_next   = '0;
                        zr_next    = '0;
                        left_next  = '0;
                        size_next  = '0;
                        ev_next    = '0;
                    end
                    else
                    begin
                        pos_next   = pos_run;
                        zr_next    = zr_reg + {2'd0, run};
                        size_next  = sym_size;
                        left_next  = sym_size;
                        ev_next    = '0;
                        phase_next = PH_AC_EXTRA;
                    end
                end
            end
            ST_END:
            begin
                if (!end_reg)
                begin
                    if (ff_reg)
                    begin
                        skip_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
                else if (phase_reg == PH_DC_SYM || can_emit)
                begin
                    // stream ended inside a block
                    if (phase_reg != PH_DC_SYM)
                    begin
                        ov_next    = 1'b1;
                        oidx_next  = '0;
                        oval_next  = '0;
                        ozb_next   = '0;
                        odone_next = 1'b1;
                        oerr_next  = 1'b1;
                        phase_next = PH_DC_SYM;
                        pos_next   = '0;
                        zr_next    = '0;
                        left_next  = '0;
                        size_next  = '0;
                        ev_next    = '0;
                    end
                    cur_next   = '0;
                    skip_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (adv)
        begin
            sh_next    = {sh_reg[6:0], 1'b0};
            cnt_next   = cnt_reg - 4'd1;
            state_next = (cnt_reg == 4'd1) ? ST_END : ST_BIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_DC_SYM;
            cur_reg   <= '0;
            left_reg  <= '0;
            size_reg  <= '0;
            ev_reg    <= '0;
            pos_reg   <= '0;
            zr_reg    <= '0;
            pred_reg  <= '0;
            skip_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            cnt_reg   <= '0;
            end_reg   <= 1'b0;
            ff_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cur_reg   <= cur_next;
            left_reg  <= left_next;
            size_reg  <= size_next;
            ev_reg    <= ev_next;
            pos_reg   <= pos_next;
            zr_reg    <= zr_next;
            pred_reg  <= pred_next;
            skip_reg  <= skip_next;
            ov_reg    <= ov_next;
            cnt_reg   <= cnt_next;
            end_reg   <= end_next;
            ff_reg    <= ff_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg    <= sh_next;
        nxt_reg   <= nxt_next;
        oidx_reg  <= oidx_next;
        oval_reg  <= oval_next;
        ozb_reg   <= ozb_next;
        odone_reg <= odone_next;
        oerr_reg  <= oerr_next;
    end

    a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && oerr_reg |-> odone_reg && oidx_reg == 6'd0)
        else $error("error word without block end");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= 7'(BLOCK_COEFS))
        else $error("coefficient position past block");

    a_walk_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD1 || state_reg == ST_RD2) |-> !phase_reg[0])
        else $error("tree walk outside a symbol phase");

    a_dc_pos: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DC_SYM |-> pos_reg == 7'd0 && zr_reg == 6'd0)
        else $error("block progress left in dc symbol phase");

endmodule

@@ bench/jhd_decoder_checker.sv @@
// jhd_decoder_checker: watches the request and result channels of the decoder core,
// predicts every result word from the accepted requests and compares them in order
// depends on jhd_pkg and the channel interfaces in jhd_channels.sv
`timescale 1ns / 100ps

module jhd_decoder_checker
    import jhd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    jhd_req_if   req,
    jhd_rsp_if   rsp,
    output int   fail_count,
    output int   pending
);

    typedef struct packed {
        logic [5:0]  idx;
        logic [15:0] val;
        logic [5:0]  zb;
        logic        done;
        logic        err;
    } coef_word_t;

    coef_word_t coef_queue[$];

    logic [NODE_BITS-1:0] tree_mem [0:2*TREE_NODES-1];
    node_t       walk_node;
    phase_t      phase;
    logic [3:0]  bits_left;
    logic [3:0]  mag_size;
    logic [15:0] extra_val;
    logic [6:0]  position;
    logic [5:0]  run_zeros;
    logic [15:0] dc_pred;
    logic        drop_byte;

    function automatic void push_word(int idx, logic [15:0] val, int zb, logic done,
                                      logic err);
        coef_word_t w;
        w.idx  = idx[5:0];
        w.val  = val;
        w.zb   = zb[5:0];
        w.done = done;
        w.err  = err;
        coef_queue.push_back(w);
    endfunction

    function automatic void clear_block();
        phase     = PH_DC_SYM;
        walk_node = '0;
        position  = '0;
        run_zeros = '0;
        bits_left = '0;
        mag_size  = '0;
        extra_val = '0;
    endfunction

    function automatic void open_ac();
        phase     = PH_AC_SYM;
        walk_node = '0;
        position  = 7'd1;
        run_zeros = '0;
    endfunction

    function automatic void open_extra(logic [3:0] sz, phase_t nxt);
        mag_size  = sz;
        bits_left = sz;
        extra_val = '0;
        phase     = nxt;
    endfunction

    function automatic void abort_block();
        push_word(0, 16'h0, 0, 1'b1, 1'b1);
        clear_block();
    endfunction

    function automatic void ac_symbol(logic [7:0] sym);
        int run;
        int sz;
        run = sym[7:4];
        sz  = sym[3:0];
        if (sz == 0) begin
            if (run == 0) begin
                push_word(63, 16'h0, run_zeros + (BLOCK_COEFS - position), 1'b1, 1'b0);
                clear_block();
            end
            else if (run == 15) begin
                if (position + 16 > BLOCK_COEFS)
                    abort_block();
                else
                begin
                    position  = position + 7'd16;
                    run_zeros = run_zeros + 6'd16;
                    if (position == BLOCK_COEFS) begin
                        push_word(63, 16'h0, run_zeros, 1'b1, 1'b0);
                        clear_block();
                    end
                end
            end
            // run 1..14 with size 0 is not a legal symbol, dropped
            return;
        end
        if (position + run > BLOCK_COEFS - 1) begin
            abort_block();
            return;
        end
        position  = position + run[6:0];
        run_zeros = run_zeros + run[5:0];
        open_extra(sz[3:0], PH_AC_EXTRA);
    endfunction

    function automatic void feed_bit(logic b);
        logic [NODE_BITS-1:0] cur_e;
        logic [NODE_BITS-1:0] nxt_e;
        logic [9:0]  base;
        node_t       nxt;
        logic [15:0] coef;
        int          s;
        logic        last;
        if (phase == PH_DC_SYM || phase == PH_AC_SYM) begin
            base  = (phase == PH_AC_SYM) ? 10'(TREE_NODES) : 10'd0;
            cur_e = tree_mem[base + walk_node];
            nxt   = b ? cur_e[16:8] : cur_e[25:17];
            nxt_e = tree_mem[base + nxt];
            if (!nxt_e[26]) begin
                walk_node = nxt;
                return;
            end
            walk_node = '0;
            if (phase == PH_DC_SYM) begin
                if (nxt_e[3:0] == 4'd0) begin
                    push_word(0, dc_pred, 0, 1'b0, 1'b0);
                    open_ac();
                end
                else
                    open_extra(nxt_e[3:0], PH_DC_EXTRA);
            end
            else
                ac_symbol(nxt_e[7:0]);
            return;
        end
        extra_val = {extra_val[14:0], b};
        if (bits_left > 0)
            bits_left = bits_left - 4'd1;
        if (bits_left == 0) begin
            s = (mag_size == 0) ? 1 : mag_size;
            if (extra_val[s-1])
                coef = extra_val;
            else
                coef = extra_val - (16'd1 << s) + 16'd1;
            if (phase == PH_DC_EXTRA) begin
                dc_pred = dc_pred + coef;
                push_word(0, dc_pred, 0, 1'b0, 1'b0);
                open_ac();
            end
            else
            begin
                last = (position >= BLOCK_COEFS - 1);
                push_word(position, coef, run_zeros, last, 1'b0);
                if (last)
                    clear_block();
                else
                begin
                    position  = position + 7'd1;
                    run_zeros = '0;
                    phase     = PH_AC_SYM;
                end
            end
        end
    endfunction

    function automatic void predict_request();
        if (req.cmd == CMD_BYTE) begin
            if (drop_byte)
                drop_byte = 1'b0;
            else
            begin
                for (int i = 7; i >= 0; i--)
                    feed_bit(req.data_byte[i]);
                if (req.data_byte == MARKER_BYTE)
                    drop_byte = 1'b1;
            end
            if (req.stream_end) begin
                if (phase != PH_DC_SYM)
                    abort_block();
                walk_node = '0;
                drop_byte = 1'b0;
            end
        end
        else if (req.cmd == CMD_LOAD) begin
            tree_mem[{req.table_select, req.node_index}] =
                {req.node_is_leaf, req.child_zero, req.child_one, req.leaf_symbol};
        end
        else if (req.cmd == CMD_RESTART) begin
            clear_block();
            dc_pred   = '0;
            drop_byte = 1'b0;
        end
    endfunction

    function automatic void check_word();
        coef_word_t w;
        if (coef_queue.size() == 0) begin
            $display("%0t: result word with nothing expected: idx %0d val %0d", $time,
                     rsp.coef_index, rsp.coef_value);
            fail_count++;
            return;
        end
        w = coef_queue.pop_front();
        if (rsp.coef_index !== w.idx) begin
            $display("%0t: coef_index expected %0d actual %0d", $time, w.idx,
                     rsp.coef_index);
            fail_count++;
        end
        if (rsp.coef_value !== w.val) begin
            $display("%0t: coef_value expected %0d actual %0d", $time,
                     $signed(w.val), rsp.coef_value);
            fail_count++;
        end
        if (rsp.zeros_before !== w.zb) begin
            $display("%0t: zeros_before expected %0d actual %0d", $time, w.zb,
                     rsp.zeros_before);
            fail_count++;
        end
        if (rsp.block_done !== w.done) begin
            $display("%0t: block_done expected %0b actual %0b", $time, w.done,
                     rsp.block_done);
            fail_count++;
        end
        if (rsp.error !== w.err) begin
            $display("%0t: error expected %0b actual %0b", $time, w.err, rsp.error);
            fail_count++;
        end
    endfunction

    initial
    begin
        fail_count = 0;
        pending    = 0;
        clear_block();
        dc_pred   = '0;
        drop_byte = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (req.valid && req.ready)
                predict_request();
            if (rsp.valid && rsp.ready)
                check_word();
        end
        pending = coef_queue.size();
    end

endmodule

@@ bench/jpeg_huffman_block_decoder_core_tb.sv @@
// jpeg_huffman_block_decoder_core_tb: stimulus and verdict for the huffman decoder core
// depends on jhd_pkg, jhd_channels.sv, the core and jhd_decoder_checker
`timescale 1ns / 100ps

module jpeg_huffman_block_decoder_core_tb;
    import jhd_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycles;
    logic long_hold_go;

    logic [7:0] ac_leaf_sym [0:15];

    jhd_req_if req_ch ();
    jhd_rsp_if rsp_ch ();

    jpeg_huffman_block_decoder_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    jhd_decoder_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    task automatic send_word(cmd_t c, logic [7:0] db, logic se, logic sel, node_t idx,
                             logic leaf, node_t c0, node_t c1, logic [7:0] sym);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid        = 1'b1;
        req_ch.cmd          = c;
        req_ch.data_byte    = db;
        req_ch.stream_end   = se;
        req_ch.table_select = sel;
        req_ch.node_index   = idx;
        req_ch.node_is_leaf = leaf;
        req_ch.child_zero   = c0;
        req_ch.child_one    = c1;
        req_ch.leaf_symbol  = sym;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    task automatic send_byte(logic [7:0] b, logic se);
        send_word(CMD_BYTE, b, se, 1'($urandom), node_t'($urandom), 1'($urandom),
                  node_t'($urandom), node_t'($urandom), 8'($urandom));
    endtask

    task automatic load_node(logic sel, node_t idx, logic leaf, node_t c0, node_t c1,
                             logic [7:0] sym);
        send_word(CMD_LOAD, 8'($urandom), 1'($urandom), sel, idx, leaf, c0, c1, sym);
    endtask

    // depth-4 complete tree: inner nodes 0..14, leaves 15..30 hold code k at 15+k
    task automatic load_code_tree(logic sel);
        for (int k = 0; k < 15; k++)
            load_node(sel, node_t'(k), 1'b0, node_t'(2*k+1), node_t'(2*k+2), 8'($urandom));
        for (int k = 0; k < 16; k++)
            load_node(sel, node_t'(15+k), 1'b1, node_t'($urandom), node_t'($urandom),
                      sel ? ac_leaf_sym[k] : {4'($urandom), 4'(k)});
    endtask

    function automatic logic [7:0] random_ac_symbol();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return 8'h00;
        if (r < 20) return 8'hF0;
        if (r < 25) return {4'($urandom_range(1, 14)), 4'h0};
        if (r < 75) return {4'($urandom_range(0, 2)), 4'($urandom_range(1, 6))};
        return {4'($urandom), 4'($urandom_range(1, 15))};
    endfunction

    task automatic restyle_ac_leaf();
        int k;
        k = $urandom_range(0, 15);
        ac_leaf_sym[k] = random_ac_symbol();
        load_node(1'b1, node_t'(15+k), 1'b1, node_t'($urandom), node_t'($urandom),
                  ac_leaf_sym[k]);
    endtask

    // receiver: random stalls, calm stretches, and one long hold-off on request
    initial
    begin
        int calm;
        int hold;
        logic held_once;
        calm = 0;
        hold = 0;
        held_once = 1'b0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_go && !held_once) begin
                held_once = 1'b1;
                hold = 1500;
            end
            if (hold > 0) begin
                hold--;
                rsp_ch.ready = 1'b0;
            end
            else if (calm > 0) begin
                calm--;
                rsp_ch.ready = 1'b1;
            end
            else
            begin
                case ($urandom_range(0, 19))
                    0: calm = $urandom_range(20, 120);
                    1: hold = $urandom_range(8, 40);
                    default: ;
                endcase
                rsp_ch.ready = ($urandom_range(0, 3) != 0);
            end
        end
    end

    initial
    begin
        int r;
        logic [7:0] b;
        long_hold_go        = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.cmd          = CMD_BYTE;
        req_ch.data_byte    = '0;
        req_ch.stream_end   = 1'b0;
        req_ch.table_select = 1'b0;
        req_ch.node_index   = '0;
        req_ch.node_is_leaf = 1'b0;
        req_ch.child_zero   = '0;
        req_ch.child_one    = '0;
        req_ch.leaf_symbol  = '0;
        ac_leaf_sym = '{8'h00, 8'hF0, 8'h50, 8'h01, 8'h02, 8'h11, 8'h03, 8'h21,
                        8'h0A, 8'h3F, 8'h0F, 8'hE1, 8'h04, 8'h12, 8'h05, 8'h31};
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // walks only ever reach nodes 0..30 of either tree
        load_code_tree(1'b0);
        load_code_tree(1'b1);

        // directed: one block per byte, dc size 0 then eob
        send_byte(8'h00, 1'b0);
        // dc size 0, then three zrl runs in the same block
        send_byte(8'h01, 1'b0);
        send_byte(8'h11, 1'b0);
        // eob, then a dc of size 2 and another eob
        send_byte(8'h02, 1'b0);
        send_byte(8'h00, 1'b0);
        // marker byte, the following byte is dropped
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h9C, 1'b0);
        // stream end in the middle of a block
        send_byte(8'h3A, 1'b1);
        // stream end on a dropped byte
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hF7, 1'b0);
        send_word(CMD_RESTART, 8'h00, 1'b0, 1'b0, '0, 1'b0, '0, '0, 8'h00);
        send_word(CMD_UNUSED, 8'hFF, 1'b1, 1'b1, '1, 1'b1, '1, '1, 8'hFF);
        send_byte(8'hE3, 1'b0);
        // root loaded as a leaf is still walked as an inner node
        load_node(1'b0, node_t'(0), 1'b1, node_t'(1), node_t'(2), 8'h00);
        send_byte(8'h00, 1'b0);
        send_byte(8'h6B, 1'b0);
        load_node(1'b0, node_t'(0), 1'b0, node_t'(1), node_t'(2), 8'h00);
        send_byte(8'hFE, 1'b1);

        long_hold_go = 1'b1;
        for (int n = 0; n < 120; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 84) begin
                b = ($urandom_range(0, 9) == 0) ? MARKER_BYTE : 8'($urandom);
                send_byte(b, $urandom_range(0, 19) == 0);
            end
            else if (r < 88)
                send_word(CMD_RESTART, 8'($urandom), 1'($urandom), 1'($urandom),
                          node_t'($urandom), 1'($urandom), node_t'($urandom),
                          node_t'($urandom), 8'($urandom));
            else if (r < 90)
                send_word(CMD_UNUSED, 8'($urandom), 1'($urandom), 1'($urandom),
                          node_t'($urandom), 1'($urandom), node_t'($urandom),
                          node_t'($urandom), 8'($urandom));
            else if (r < 98)
                restyle_ac_leaf();
            else
                load_node(1'b0, node_t'(15 + $urandom_range(0, 15)), 1'b1,
                          node_t'($urandom), node_t'($urandom), 8'($urandom));
        end
        req_ch.valid = 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
